FILE: sv/bfpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared types and codes for the best-fit partition allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

   localparam int WORD_W   = 13;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 6;
   localparam int START_W  = 12;
   localparam int CTR_W    = 16;
   localparam int NAME_W   = 16;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_ALLOC = 2'd2,
      OP_FREE  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 3'd0,
      STAT_NOFIT   = 3'd1,
      STAT_INUSE   = 3'd2,
      STAT_UNKNOWN = 3'd3,
      STAT_FULL    = 3'd4,
      STAT_BAD     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESOLVE
   } state_type;

endpackage

FILE: sv/bfpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/best_fit_partition_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_partition_allocator
// Fixed-partition allocator with best-fit choice over a table held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid / req_stall with req_type, req_owner_name and
//   req_word_count: add a partition, clear the table, allocate or free.
//   Each request yields one response on rsp_valid / rsp_stall carrying the
//   status, the partition index, start and leftover words, and the two
//   saturating allocate counters.
//   Add and clear go from acceptance straight to the resolve state. Allocate
//   and free read the partition table once per entry through the single RAM
//   read port in the scan state, then pass a drain state before resolve; a
//   rejected name or size skips the scan and goes straight to resolve.
//   One request is in work at a time; the next one is accepted the cycle
//   after the response is loaded, even while that response still waits in
//   the output register.
//   When rsp_stall holds the output register full, the finished request
//   waits before its table write-back and the input stays stalled.
//   Write the memory size register (csr_valid / csr_ready) only while idle;
//   the block leaves this to the user. Reset empties the table at once
//   via the fill count (no clearing pass); zeroes counters and memory size.
// ----------------------------------------------------------------------------
module best_fit_partition_allocator #(
   parameter int MAX_PARTS = 64,
   parameter int ADDR_BITS = 12,
   parameter int NAME_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic [bfpa_pkg::NAME_W-1:0]       req_owner_name,
   input  logic [bfpa_pkg::WORD_W-1:0]       req_word_count,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bfpa_pkg::STATUS_W-1:0]     rsp_status,
   output logic [bfpa_pkg::INDEX_W-1:0]      rsp_part_index,
   output logic [bfpa_pkg::START_W-1:0]      rsp_part_start,
   output logic [bfpa_pkg::WORD_W-1:0]       rsp_leftover_words,
   output logic [bfpa_pkg::CTR_W-1:0]        rsp_alloc_requests,
   output logic [bfpa_pkg::CTR_W-1:0]        rsp_alloc_successes,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bfpa_pkg::WORD_W-1:0]       csr_memory_words
);

   localparam int WW    = bfpa_pkg::WORD_W;
   localparam int NB    = (NAME_BITS < bfpa_pkg::NAME_W) ? NAME_BITS : bfpa_pkg::NAME_W;
   localparam int IDX_W = $clog2(MAX_PARTS);
   localparam int CNT_W = $clog2(MAX_PARTS + 1);
   localparam int ENT_W = NB + WW + ADDR_BITS;
   localparam logic [24:0] CAP = 25'(1) << ADDR_BITS;
   localparam logic [bfpa_pkg::CTR_W-1:0] CTR_MAX = '1;

   bfpa_pkg::state_type state_ff, state_in;

   logic [WW-1:0]       mem_words_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [WW-1:0]       nfs_ff, nfs_in;
   logic [bfpa_pkg::CTR_W-1:0] req_ctr_ff, succ_ctr_ff, succ_ctr_in;

   bfpa_pkg::op_type    op_ff;
   logic [NB-1:0]       name_ff;
   logic [WW-1:0]       words_ff;

   logic [CNT_W-1:0]    issue_ff;
   logic                rd_valid_ff;
   logic [IDX_W-1:0]    rd_idx_ff;

   logic                found_ff, found_in;
   logic                inuse_ff, inuse_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [WW-1:0]       best_left_ff, best_left_in;
   logic [ADDR_BITS-1:0] best_start_ff, best_start_in;

   logic                rsp_valid_ff;
   logic [bfpa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [IDX_W-1:0]    rsp_idx_ff;
   logic [ADDR_BITS-1:0] rsp_start_ff;
   logic [WW-1:0]       rsp_left_ff;
   logic [bfpa_pkg::CTR_W-1:0] rsp_req_ff, rsp_succ_ff;

   logic                accept;
   logic                rd_en;
   logic                fire;
   logic                last_issue;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [ENT_W-1:0]    wr_data;
   logic [ENT_W-1:0]    rd_data;

   logic [NB-1:0]       rd_owner;
   logic [WW-1:0]       rd_size;
   logic [ADDR_BITS-1:0] rd_start;
   logic                rd_busy;
   logic [WW-1:0]       rd_left;

   logic [WW-1:0]       mem_limit;
   bfpa_pkg::status_type res_status;
   logic [IDX_W-1:0]    res_idx;
   logic [ADDR_BITS-1:0] res_start;
   logic [WW-1:0]       res_left;

   bfpa_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_PARTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign last_issue = ((CNT_W + 1)'(issue_ff) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfpa_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (bfpa_pkg::op_type'(req_type))
                  bfpa_pkg::OP_ALLOC: begin
                     if ((req_owner_name[NB-1:0] == '0) || (req_word_count == '0)) begin
                        state_in = bfpa_pkg::ST_RESOLVE;
                     end else begin
                        state_in = bfpa_pkg::ST_SCAN;
                     end
                  end
                  bfpa_pkg::OP_FREE: begin
                     if (req_owner_name[NB-1:0] == '0) begin
                        state_in = bfpa_pkg::ST_RESOLVE;
                     end else begin
                        state_in = bfpa_pkg::ST_SCAN;
                     end
                  end
                  default: state_in = bfpa_pkg::ST_RESOLVE;
               endcase
            end
         end
         bfpa_pkg::ST_SCAN: begin
            if (last_issue) begin
               state_in = bfpa_pkg::ST_DRAIN;
            end
         end
         bfpa_pkg::ST_DRAIN: state_in = bfpa_pkg::ST_RESOLVE;
         bfpa_pkg::ST_RESOLVE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = bfpa_pkg::ST_IDLE;
            end
         end
         default: state_in = bfpa_pkg::ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      fire      = 1'b0;
      case (state_ff)
         bfpa_pkg::ST_IDLE:    req_stall = 1'b0;
         bfpa_pkg::ST_SCAN:    rd_en = (issue_ff < count_ff);
         bfpa_pkg::ST_DRAIN:   rd_en = 1'b0;
         bfpa_pkg::ST_RESOLVE: fire = !rsp_valid_ff || !rsp_stall;
         default:              req_stall = 1'b1;
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // scan compare
   assign rd_owner = rd_data[ENT_W-1 -: NB];
   assign rd_size  = rd_data[ADDR_BITS +: WW];
   assign rd_start = rd_data[ADDR_BITS-1:0];
   assign rd_busy  = (rd_owner != '0);
   assign rd_left  = rd_size - words_ff;

   always_comb begin
      found_in      = found_ff;
      inuse_in      = inuse_ff;
      best_idx_in   = best_idx_ff;
      best_left_in  = best_left_ff;
      best_start_in = best_start_ff;
      if (rd_valid_ff) begin
         if (op_ff == bfpa_pkg::OP_ALLOC) begin
            if (rd_busy && (rd_owner == name_ff)) begin
               inuse_in = 1'b1;
            end
            if (!rd_busy && (rd_size >= words_ff) && (!found_ff || (rd_left < best_left_ff))) begin
               found_in      = 1'b1;
               best_idx_in   = rd_idx_ff;
               best_left_in  = rd_left;
               best_start_in = rd_start;
            end
         end else if (rd_busy && (rd_owner == name_ff) && !found_ff) begin
            found_in      = 1'b1;
            best_idx_in   = rd_idx_ff;
            best_left_in  = rd_size;
            best_start_in = rd_start;
         end
      end
   end

   // resolve and write back
   always_comb begin
      mem_limit   = (25'(mem_words_ff) < CAP) ? mem_words_ff : WW'(CAP);
      res_status  = bfpa_pkg::STAT_OK;
      res_idx     = '0;
      res_start   = '0;
      res_left    = '0;
      wr_en       = 1'b0;
      wr_addr     = best_idx_ff;
      wr_data     = {NB'(0), best_left_ff, best_start_ff};
      count_in    = count_ff;
      nfs_in      = nfs_ff;
      succ_ctr_in = succ_ctr_ff;
      case (op_ff)
         bfpa_pkg::OP_ADD: begin
            if (words_ff == '0) begin
               res_status = bfpa_pkg::STAT_BAD;
            end else if ((count_ff >= CNT_W'(MAX_PARTS)) ||
                         ((WW + 1)'(nfs_ff) + (WW + 1)'(words_ff) > (WW + 1)'(mem_limit))) begin
               res_status = bfpa_pkg::STAT_FULL;
            end else begin
               res_idx   = count_ff[IDX_W-1:0];
               res_start = ADDR_BITS'(nfs_ff);
               res_left  = words_ff;
               wr_en     = fire;
               wr_addr   = count_ff[IDX_W-1:0];
               wr_data   = {NB'(0), words_ff, ADDR_BITS'(nfs_ff)};
               count_in  = count_ff + CNT_W'(1);
               nfs_in    = nfs_ff + words_ff;
            end
         end
         bfpa_pkg::OP_CLEAR: begin
            count_in = '0;
            nfs_in   = '0;
         end
         bfpa_pkg::OP_ALLOC: begin
            if ((name_ff == '0) || (words_ff == '0)) begin
               res_status = bfpa_pkg::STAT_BAD;
            end else if (inuse_ff) begin
               res_status = bfpa_pkg::STAT_INUSE;
            end else if (!found_ff) begin
               res_status = bfpa_pkg::STAT_NOFIT;
            end else begin
               res_idx   = best_idx_ff;
               res_start = best_start_ff;
               res_left  = best_left_ff;
               wr_en     = fire;
               wr_data   = {name_ff, best_left_ff + words_ff, best_start_ff};
               if (succ_ctr_ff != CTR_MAX) begin
                  succ_ctr_in = succ_ctr_ff + bfpa_pkg::CTR_W'(1);
               end
            end
         end
         bfpa_pkg::OP_FREE: begin
            if (name_ff == '0) begin
               res_status = bfpa_pkg::STAT_BAD;
            end else if (!found_ff) begin
               res_status = bfpa_pkg::STAT_UNKNOWN;
            end else begin
               res_idx   = best_idx_ff;
               res_start = best_start_ff;
               res_left  = best_left_ff;
               wr_en     = fire;
            end
         end
         default: res_status = bfpa_pkg::STAT_BAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfpa_pkg::ST_IDLE;
         mem_words_ff <= '0;
         count_ff     <= '0;
         nfs_ff       <= '0;
         req_ctr_ff   <= '0;
         succ_ctr_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_en;
         if (csr_valid && csr_ready) begin
            mem_words_ff <= csr_memory_words;
         end
         if (accept && (bfpa_pkg::op_type'(req_type) == bfpa_pkg::OP_ALLOC) &&
             (req_ctr_ff != CTR_MAX)) begin
            req_ctr_ff <= req_ctr_ff + bfpa_pkg::CTR_W'(1);
         end
         if (fire) begin
            count_ff     <= count_in;
            nfs_ff       <= nfs_in;
            succ_ctr_ff  <= succ_ctr_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= bfpa_pkg::op_type'(req_type);
         name_ff  <= req_owner_name[NB-1:0];
         words_ff <= req_word_count;
         issue_ff <= '0;
         found_ff <= 1'b0;
         inuse_ff <= 1'b0;
      end else begin
         found_ff      <= found_in;
         inuse_ff      <= inuse_in;
         best_idx_ff   <= best_idx_in;
         best_left_ff  <= best_left_in;
         best_start_ff <= best_start_in;
         if (rd_en) begin
            issue_ff <= issue_ff + CNT_W'(1);
         end
      end
      rd_idx_ff <= issue_ff[IDX_W-1:0];
      if (fire) begin
         rsp_status_ff <= res_status;
         rsp_idx_ff    <= res_idx;
         rsp_start_ff  <= res_start;
         rsp_left_ff   <= res_left;
         rsp_req_ff    <= req_ctr_ff;
         rsp_succ_ff   <= succ_ctr_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_part_index      = bfpa_pkg::INDEX_W'(rsp_idx_ff);
   assign rsp_part_start      = bfpa_pkg::START_W'(rsp_start_ff);
   assign rsp_leftover_words  = rsp_left_ff;
   assign rsp_alloc_requests  = rsp_req_ff;
   assign rsp_alloc_successes = rsp_succ_ff;

`ifndef NO_ASSERTIONS
   a_write_only_resolve: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == bfpa_pkg::ST_RESOLVE))
      else $error("table write outside resolve");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PARTS))
      else $error("partition count beyond table depth");

   a_read_in_fill: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (CNT_W'(rd_idx_ff) < count_ff))
      else $error("scan read beyond filled entries");

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_valid && (state_ff == bfpa_pkg::ST_IDLE)))
      else $error("finished request produced no response");
`endif

endmodule

FILE: bench/best_fit_partition_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_partition_allocator_test
// Self-checking bench for the best-fit partition allocator. An opening table
// walks the error codes, the memory limits, best-fit ties and
// reuse of freed partitions; random phases follow under several memory sizes
// with random gaps and stalls on both sides and long response hold-offs.
// Every response is compared field by field with its scripted reply or an
// in-bench model of the table.
// ----------------------------------------------------------------------------
module best_fit_partition_allocator_test;

   localparam int MAX_PARTS    = 64;
   localparam int ADDR_LIMIT   = 4096;
   localparam int CTR_MAX      = 65535;
   localparam int SCRIPT_LEN   = 28;
   localparam int PHASE_ITEMS  = 115;
   localparam int PHASES       = 8;
   localparam int DRAIN_CYCLES = 80;
   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_OFF     = 400;

   typedef struct packed {
      bfpa_pkg::status_type                status;
      logic [bfpa_pkg::INDEX_W-1:0]        part_index;
      logic [bfpa_pkg::START_W-1:0]        part_start;
      logic [bfpa_pkg::WORD_W-1:0]         leftover_words;
      logic [bfpa_pkg::CTR_W-1:0]          alloc_requests;
      logic [bfpa_pkg::CTR_W-1:0]          alloc_successes;
   } alloc_response_type;

   typedef struct packed {
      logic                                csr_write;
      bfpa_pkg::op_type                    op;
      logic [bfpa_pkg::NAME_W-1:0]         name;
      logic [bfpa_pkg::WORD_W-1:0]         words;
      logic                                typed;
      bfpa_pkg::status_type                status;
      logic [bfpa_pkg::INDEX_W-1:0]        part_index;
      logic [bfpa_pkg::START_W-1:0]        part_start;
      logic [bfpa_pkg::WORD_W-1:0]         leftover_words;
      logic [bfpa_pkg::CTR_W-1:0]          alloc_requests;
      logic [bfpa_pkg::CTR_W-1:0]          alloc_successes;
   } script_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [1:0]                          req_type;
   logic [bfpa_pkg::NAME_W-1:0]         req_owner_name;
   logic [bfpa_pkg::WORD_W-1:0]         req_word_count;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic [bfpa_pkg::STATUS_W-1:0]       rsp_status;
   logic [bfpa_pkg::INDEX_W-1:0]        rsp_part_index;
   logic [bfpa_pkg::START_W-1:0]        rsp_part_start;
   logic [bfpa_pkg::WORD_W-1:0]         rsp_leftover_words;
   logic [bfpa_pkg::CTR_W-1:0]          rsp_alloc_requests;
   logic [bfpa_pkg::CTR_W-1:0]          rsp_alloc_successes;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [bfpa_pkg::WORD_W-1:0]         csr_memory_words;

   // model of the partition table
   int                          slot_start [MAX_PARTS];
   int                          slot_size [MAX_PARTS];
   bit                          slot_busy [MAX_PARTS];
   bit [bfpa_pkg::NAME_W-1:0]   slot_owner [MAX_PARTS];
   int                          table_fill;
   int                          fill_point;
   int                          seen_allocs;
   int                          granted_allocs;
   int                          memory_size;

   alloc_response_type          pending_responses [$];
   script_row_type              opening_script [0:SCRIPT_LEN-1];
   logic [bfpa_pkg::NAME_W-1:0] owner_pool [8];

   int mismatch_count;
   int responses_checked;
   int requests_sent;
   int op_tally [4];
   int peak_fill;
   int size_settings;
   int hold_off_cycles;
   bit steady;

   best_fit_partition_allocator dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_owner_name      (req_owner_name),
      .req_word_count      (req_word_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_part_index      (rsp_part_index),
      .rsp_part_start      (rsp_part_start),
      .rsp_leftover_words  (rsp_leftover_words),
      .rsp_alloc_requests  (rsp_alloc_requests),
      .rsp_alloc_successes (rsp_alloc_successes),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_memory_words    (csr_memory_words)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int slot_held_by(logic [bfpa_pkg::NAME_W-1:0] name);
      int i;
      for (i = 0; i < table_fill; i++) begin
         if (slot_busy[i] && slot_owner[i] == name) return i;
      end
      return -1;
   endfunction

   function automatic alloc_response_type allocator_outcome(
         bfpa_pkg::op_type op, logic [bfpa_pkg::NAME_W-1:0] name,
         logic [bfpa_pkg::WORD_W-1:0] words);
      alloc_response_type r;
      int limit, best, best_left, held, i;
      bit found;
      r = '0;
      limit = memory_size < ADDR_LIMIT ? memory_size : ADDR_LIMIT;
      case (op)
         bfpa_pkg::OP_ADD: begin
            if (words == 0) begin
               r.status = bfpa_pkg::STAT_BAD;
            end else if (table_fill >= MAX_PARTS || fill_point + int'(words) > limit) begin
               r.status = bfpa_pkg::STAT_FULL;
            end else begin
               slot_start[table_fill] = fill_point;
               slot_size[table_fill]  = int'(words);
               slot_busy[table_fill]  = 1'b0;
               slot_owner[table_fill] = '0;
               r.part_index     = bfpa_pkg::INDEX_W'(table_fill);
               r.part_start     = bfpa_pkg::START_W'(fill_point);
               r.leftover_words = words;
               fill_point += int'(words);
               table_fill++;
            end
         end
         bfpa_pkg::OP_CLEAR: begin
            for (i = 0; i < MAX_PARTS; i++) begin
               slot_busy[i]  = 1'b0;
               slot_owner[i] = '0;
            end
            table_fill = 0;
            fill_point = 0;
         end
         bfpa_pkg::OP_ALLOC: begin
            if (seen_allocs < CTR_MAX) seen_allocs++;
            if (name == 0 || words == 0) begin
               r.status = bfpa_pkg::STAT_BAD;
            end else if (slot_held_by(name) >= 0) begin
               r.status = bfpa_pkg::STAT_INUSE;
            end else begin
               found = 1'b0;
               best = 0;
               best_left = 0;
               for (i = 0; i < table_fill; i++) begin
                  if (!slot_busy[i] && slot_size[i] >= int'(words)) begin
                     if (!found || slot_size[i] - int'(words) < best_left) begin
                        found = 1'b1;
                        best = i;
                        best_left = slot_size[i] - int'(words);
                     end
                  end
               end
               if (!found) begin
                  r.status = bfpa_pkg::STAT_NOFIT;
               end else begin
                  slot_busy[best]  = 1'b1;
                  slot_owner[best] = name;
                  if (granted_allocs < CTR_MAX) granted_allocs++;
                  r.part_index     = bfpa_pkg::INDEX_W'(best);
                  r.part_start     = bfpa_pkg::START_W'(slot_start[best]);
                  r.leftover_words = bfpa_pkg::WORD_W'(best_left);
               end
            end
         end
         default: begin
            if (name == 0) begin
               r.status = bfpa_pkg::STAT_BAD;
            end else begin
               held = slot_held_by(name);
               if (held < 0) begin
                  r.status = bfpa_pkg::STAT_UNKNOWN;
               end else begin
                  slot_busy[held]  = 1'b0;
                  slot_owner[held] = '0;
                  r.part_index     = bfpa_pkg::INDEX_W'(held);
                  r.part_start     = bfpa_pkg::START_W'(slot_start[held]);
                  r.leftover_words = bfpa_pkg::WORD_W'(slot_size[held]);
               end
            end
         end
      endcase
      r.alloc_requests  = bfpa_pkg::CTR_W'(seen_allocs);
      r.alloc_successes = bfpa_pkg::CTR_W'(granted_allocs);
      return r;
   endfunction

   function automatic int sender_gap();
      int pick;
      if (steady) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic send_request(bfpa_pkg::op_type op, logic [bfpa_pkg::NAME_W-1:0] name,
                               logic [bfpa_pkg::WORD_W-1:0] words, bit typed,
                               alloc_response_type typed_reply);
      alloc_response_type predicted;
      int gap;
      req_valid      <= 1'b1;
      req_type       <= op;
      req_owner_name <= name;
      req_word_count <= words;
      do @(posedge clock); while (req_stall);
      predicted = allocator_outcome(op, name, words);
      pending_responses.push_back(typed ? typed_reply : predicted);
      op_tally[int'(op)]++;
      requests_sent++;
      if (table_fill > peak_fill) peak_fill = table_fill;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic set_memory_size(logic [bfpa_pkg::WORD_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      csr_valid        <= 1'b1;
      csr_memory_words <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      memory_size = value;
      size_settings++;
   endtask

   task automatic pick_request(int add_max, output bfpa_pkg::op_type op,
                               output logic [bfpa_pkg::NAME_W-1:0] name,
                               output logic [bfpa_pkg::WORD_W-1:0] words);
      int pick;
      pick  = $urandom_range(0, 99);
      name  = owner_pool[$urandom_range(0, 7)];
      words = bfpa_pkg::WORD_W'($urandom_range(1, add_max));
      if (pick < 8) begin
         op    = bfpa_pkg::op_type'($urandom_range(0, 3));
         name  = ($urandom_range(0, 3) == 0) ? '0 : bfpa_pkg::NAME_W'($urandom);
         words = ($urandom_range(0, 3) == 0) ? '0 : bfpa_pkg::WORD_W'($urandom);
      end else if (pick < 14) begin
         op = bfpa_pkg::OP_ADD;
      end else if (pick < 16) begin
         op = bfpa_pkg::OP_CLEAR;
      end else if (pick < 58) begin
         op = bfpa_pkg::OP_ALLOC;
      end else begin
         op = bfpa_pkg::OP_FREE;
      end
   endtask

   initial begin : drive_rsp_stall
      int pick, span;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            span = hold_off_cycles;
            hold_off_cycles = 0;
         end else if (steady) begin
            rsp_stall <= 1'b0;
            span = 0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               rsp_stall <= 1'b0;
               span = $urandom_range(0, 7);
            end else if (pick < 88) begin
               rsp_stall <= 1'b1;
               span = $urandom_range(0, 2);
            end else if (pick < 97) begin
               rsp_stall <= 1'b1;
               span = $urandom_range(3, 19);
            end else begin
               rsp_stall <= 1'b1;
               span = $urandom_range(30, 120);
            end
         end
         repeat (span) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_responses
      alloc_response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_responses.pop_front();
            responses_checked++;
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_part_index !== want.part_index) begin
               $error("part_index: expected %0d, got %0d", want.part_index, rsp_part_index);
               mismatch_count++;
            end
            if (rsp_part_start !== want.part_start) begin
               $error("part_start: expected %0d, got %0d", want.part_start, rsp_part_start);
               mismatch_count++;
            end
            if (rsp_leftover_words !== want.leftover_words) begin
               $error("leftover_words: expected %0d, got %0d",
                      want.leftover_words, rsp_leftover_words);
               mismatch_count++;
            end
            if (rsp_alloc_requests !== want.alloc_requests) begin
               $error("alloc_requests: expected %0d, got %0d",
                      want.alloc_requests, rsp_alloc_requests);
               mismatch_count++;
            end
            if (rsp_alloc_successes !== want.alloc_successes) begin
               $error("alloc_successes: expected %0d, got %0d",
                      want.alloc_successes, rsp_alloc_successes);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      script_row_type              row;
      alloc_response_type          typed_reply;
      bfpa_pkg::op_type            op;
      logic [bfpa_pkg::NAME_W-1:0] name;
      logic [bfpa_pkg::WORD_W-1:0] words;
      logic [bfpa_pkg::WORD_W-1:0] mem_value;
      int                          phase, n, k, add_max, add_burst;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_type         <= bfpa_pkg::OP_ADD;
      req_owner_name   <= '0;
      req_word_count   <= '0;
      csr_valid        <= 1'b0;
      csr_memory_words <= '0;

      opening_script[0]  = '{1'b0, bfpa_pkg::OP_ADD, 16'h0000, 13'd0, 1'b1,
                             bfpa_pkg::STAT_BAD, 6'd0, 12'd0, 13'd0, 16'd0, 16'd0};
      opening_script[1]  = '{1'b0, bfpa_pkg::OP_ADD, 16'h0000, 13'd1, 1'b1,
                             bfpa_pkg::STAT_FULL, 6'd0, 12'd0, 13'd0, 16'd0, 16'd0};
      opening_script[2]  = '{1'b0, bfpa_pkg::OP_ALLOC, 16'h0000, 13'd5, 1'b1,
                             bfpa_pkg::STAT_BAD, 6'd0, 12'd0, 13'd0, 16'd1, 16'd0};
      opening_script[3]  = '{1'b0, bfpa_pkg::OP_ALLOC, 16'h0007, 13'd0, 1'b1,
                             bfpa_pkg::STAT_BAD, 6'd0, 12'd0, 13'd0, 16'd2, 16'd0};
      opening_script[4]  = '{1'b0, bfpa_pkg::OP_ALLOC, 16'h0007, 13'd5, 1'b1,
                             bfpa_pkg::STAT_NOFIT, 6'd0, 12'd0, 13'd0, 16'd3, 16'd0};
      opening_script[5]  = '{1'b0, bfpa_pkg::OP_FREE, 16'h0000, 13'd0, 1'b1,
                             bfpa_pkg::STAT_BAD, 6'd0, 12'd0, 13'd0, 16'd3, 16'd0};
      opening_script[6]  = '{1'b0, bfpa_pkg::OP_FREE, 16'hFFFF, 13'd0, 1'b1,
                             bfpa_pkg::STAT_UNKNOWN, 6'd0, 12'd0, 13'd0, 16'd3, 16'd0};
      opening_script[7]  = '{1'b0, bfpa_pkg::OP_CLEAR, 16'hFFFF, 13'h1FFF, 1'b1,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd3, 16'd0};
      opening_script[8]  = '{1'b1, bfpa_pkg::OP_CLEAR, 16'h0000, 13'h1FFF, 1'b0,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd0, 16'd0};
      opening_script[9]  = '{1'b0, bfpa_pkg::OP_ADD, 16'h0000, 13'd4096, 1'b1,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd4096, 16'd3, 16'd0};
      opening_script[10] = '{1'b0, bfpa_pkg::OP_ADD, 16'h0000, 13'd1, 1'b1,
                             bfpa_pkg::STAT_FULL, 6'd0, 12'd0, 13'd0, 16'd3, 16'd0};
      opening_script[11] = '{1'b0, bfpa_pkg::OP_ALLOC, 16'hFFFF, 13'h1FFF, 1'b1,
                             bfpa_pkg::STAT_NOFIT, 6'd0, 12'd0, 13'd0, 16'd4, 16'd0};
      opening_script[12] = '{1'b0, bfpa_pkg::OP_ALLOC, 16'hFFFF, 13'd4096, 1'b1,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd5, 16'd1};
      opening_script[13] = '{1'b0, bfpa_pkg::OP_ALLOC, 16'hFFFF, 13'd1, 1'b1,
                             bfpa_pkg::STAT_INUSE, 6'd0, 12'd0, 13'd0, 16'd6, 16'd1};
      opening_script[14] = '{1'b0, bfpa_pkg::OP_FREE, 16'hFFFF, 13'd0, 1'b1,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd4096, 16'd6, 16'd1};
      opening_script[15] = '{1'b0, bfpa_pkg::OP_CLEAR, 16'h0000, 13'd0, 1'b1,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd6, 16'd1};
      opening_script[16] = '{1'b1, bfpa_pkg::OP_CLEAR, 16'h0000, 13'd100, 1'b0,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd0, 16'd0};
      opening_script[17] = '{1'b0, bfpa_pkg::OP_ADD, 16'h0000, 13'd30, 1'b0,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd0, 16'd0};
      opening_script[18] = '{1'b0, bfpa_pkg::OP_ADD, 16'h0000, 13'd10, 1'b0,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd0, 16'd0};
      opening_script[19] = '{1'b0, bfpa_pkg::OP_ADD, 16'h0000, 13'd30, 1'b0,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd0, 16'd0};
      opening_script[20] = '{1'b0, bfpa_pkg::OP_ADD, 16'h0000, 13'd30, 1'b0,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd0, 16'd0};
      opening_script[21] = '{1'b0, bfpa_pkg::OP_ADD, 16'h0000, 13'd1, 1'b0,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd0, 16'd0};
      opening_script[22] = '{1'b0, bfpa_pkg::OP_ALLOC, 16'h0001, 13'd10, 1'b0,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd0, 16'd0};
      opening_script[23] = '{1'b0, bfpa_pkg::OP_ALLOC, 16'h0002, 13'd25, 1'b0,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd0, 16'd0};
      opening_script[24] = '{1'b0, bfpa_pkg::OP_ALLOC, 16'h0003, 13'd30, 1'b0,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd0, 16'd0};
      opening_script[25] = '{1'b0, bfpa_pkg::OP_FREE, 16'h0001, 13'd0, 1'b0,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd0, 16'd0};
      opening_script[26] = '{1'b0, bfpa_pkg::OP_ALLOC, 16'h8000, 13'd10, 1'b0,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd0, 16'd0};
      opening_script[27] = '{1'b0, bfpa_pkg::OP_FREE, 16'h0003, 13'd0, 1'b0,
                             bfpa_pkg::STAT_OK, 6'd0, 12'd0, 13'd0, 16'd0, 16'd0};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < SCRIPT_LEN; n++) begin
         row = opening_script[n];
         if (row.csr_write) begin
            set_memory_size(row.words);
         end else begin
            typed_reply = '{row.status, row.part_index, row.part_start, row.leftover_words,
                            row.alloc_requests, row.alloc_successes};
            send_request(row.op, row.name, row.words, row.typed, typed_reply);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin mem_value = 13'd4096; add_max = 8;   add_burst = 70; end
            1: begin mem_value = 13'h1FFF; add_max = 400; add_burst = 14; end
            2: begin mem_value = 13'd1;    add_max = 1;   add_burst = 3;  end
            3: begin mem_value = 13'd37;   add_max = 6;   add_burst = 10; end
            5: begin mem_value = 13'd0;    add_max = 4;   add_burst = 3;  end
            6: begin mem_value = 13'd4095; add_max = 64;  add_burst = 40; end
            default: begin
               mem_value = bfpa_pkg::WORD_W'($urandom_range(0, 8191));
               add_max   = $urandom_range(1, 512);
               add_burst = $urandom_range(2, 40);
            end
         endcase
         set_memory_size(mem_value);
         steady = (phase % 3 == 1);
         // hold responses back so the block fills and stalls its input
         if (phase == 1 || phase == 4) hold_off_cycles = HOLD_OFF;
         for (k = 0; k < 8; k++) owner_pool[k] = bfpa_pkg::NAME_W'($urandom_range(1, 65535));
         if ($urandom_range(0, 3) != 0) send_request(bfpa_pkg::OP_CLEAR, '0, '0, 1'b0, '0);
         for (k = 0; k < add_burst; k++) begin
            send_request(bfpa_pkg::OP_ADD, bfpa_pkg::NAME_W'($urandom),
                         bfpa_pkg::WORD_W'($urandom_range(1, add_max)), 1'b0, '0);
         end
         for (k = add_burst; k < PHASE_ITEMS; k++) begin
            pick_request(add_max, op, name, words);
            send_request(op, name, words, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d add, %0d clear, %0d allocate, %0d free) over %0d %s",
               requests_sent, op_tally[0], op_tally[1], op_tally[2], op_tally[3],
               size_settings, "memory size settings");
      $display("Checked %0d responses; table peaked at %0d partitions; counters ended %0d/%0d",
               responses_checked, peak_fill, seen_allocs, granted_allocs);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/bfpa_pkg.sv
sv/bfpa_ram.sv
sv/best_fit_partition_allocator.sv
bench/best_fit_partition_allocator_test.sv
